// ===== rtl/lhs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhs_pkg
// Shared types, codes and header length lookup for the link header stripper.
// ----------------------------------------------------------------------------
package lhs_pkg;

    localparam int unsigned KIND_W   = 4;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned SHIFT_W  = 24;

    localparam logic [KIND_W-1:0] KIND_ETHERNET = 4'd0;
    localparam logic [KIND_W-1:0] KIND_802      = 4'd1;
    localparam logic [KIND_W-1:0] KIND_NULL     = 4'd2;
    localparam logic [KIND_W-1:0] KIND_SLIP     = 4'd3;
    localparam logic [KIND_W-1:0] KIND_PPP      = 4'd4;
    localparam logic [KIND_W-1:0] KIND_RAW      = 4'd5;
    localparam logic [KIND_W-1:0] KIND_FDDI     = 4'd6;
    localparam logic [KIND_W-1:0] KIND_ENC      = 4'd7;
    localparam logic [KIND_W-1:0] KIND_NFLOG    = 4'd8;
    localparam logic [KIND_W-1:0] KIND_SLL      = 4'd9;
    localparam logic [KIND_W-1:0] KIND_IPNET    = 4'd10;

    localparam logic [STATUS_W-1:0] STATUS_PAYLOAD   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SHORT     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MALFORMED = 2'd2;

    localparam logic [LEN_W-1:0]  VLAN_TAG_LEN     = 16'd4;
    localparam logic [LEN_W-1:0]  TLV_HDR_LEN      = 16'd4;
    localparam logic [LEN_W:0]    TLV_MIN_SPAN     = 17'd8;
    localparam logic [LEN_W-1:0]  TLV_PAYLOAD_TYPE = 16'd9;
    localparam logic [BYTE_W-1:0] VLAN_TPID_HIGH   = 8'h81;
    localparam logic [BYTE_W-1:0] VLAN_TPID_LOW    = 8'h00;

    localparam logic [LEN_W-1:0] ETH_TYPE_POS = 16'd12;
    localparam logic [LEN_W-1:0] SLL_TYPE_POS = 16'd14;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic                out_last;
        logic [STATUS_W-1:0] status;
    } t_result;

    function automatic logic [LEN_W-1:0] hdr_len_of_kind(input logic [KIND_W-1:0] kind);
        logic [LEN_W-1:0] len;
        len = '0;
        case (kind)
            KIND_ETHERNET: len = 16'd14;
            KIND_802:      len = 16'd22;
            KIND_NULL:     len = 16'd4;
            KIND_SLIP:     len = 16'd16;
            KIND_PPP:      len = 16'd4;
            KIND_RAW:      len = 16'd0;
            KIND_FDDI:     len = 16'd21;
            KIND_ENC:      len = 16'd12;
            KIND_NFLOG:    len = 16'd4;
            KIND_SLL:      len = 16'd16;
            KIND_IPNET:    len = 16'd24;
            default:       len = 16'd0;
        endcase
        return len;
    endfunction

    function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                                 input logic [LEN_W:0] b);
        logic [LEN_W+1:0] sum;
        sum = {2'b00, a} + {1'b0, b};
        return (sum[LEN_W+1:LEN_W] != 2'b00) ? {LEN_W{1'b1}} : sum[LEN_W-1:0];
    endfunction

endpackage

// ===== rtl/link_header_stripper_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_header_stripper_core
// Strips the link-layer header from captured packet bytes.
// ----------------------------------------------------------------------------
// Channel   Handshake                    Payload
// input     i_in_valid / o_in_stall      data_byte, first_byte, last_byte, packet_length
// output    o_out_valid / i_out_stall    out_byte, out_last, status
// config    i_link_kind_we               link_kind
//
// Input stalls only while the queue is full; otherwise one byte is accepted per
// cycle. The front classifies each byte in the cycle it is accepted and pushes
// at most one result into the two-entry queue, where it waits for the output
// side. Reset is synchronous and active low and empties the queue.
// ----------------------------------------------------------------------------
module link_header_stripper_core #(
    parameter int unsigned MAX_PACKET_BYTES = 65535
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_link_kind_we,
    input  logic [lhs_pkg::KIND_W-1:0]    i_link_kind,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lhs_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                          i_first_byte,
    input  logic                          i_last_byte,
    input  logic [lhs_pkg::LEN_W-1:0]     i_packet_length,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [lhs_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                          o_out_last,
    output logic [lhs_pkg::STATUS_W-1:0]  o_status
);
    import lhs_pkg::*;

    logic    fire;
    logic    push;
    logic    full;
    t_result push_result;
    t_result out_result;

    assign o_in_stall = full;
    assign fire       = i_in_valid && !full;

    lhs_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_link_kind_we  (i_link_kind_we),
        .i_link_kind     (i_link_kind),
        .i_fire          (fire),
        .i_data_byte     (i_data_byte),
        .i_first_byte    (i_first_byte),
        .i_last_byte     (i_last_byte),
        .i_packet_length (i_packet_length),
        .o_push          (push),
        .o_result        (push_result)
    );

    lhs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (push_result),
        .o_full   (full),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_result)
    );

    assign o_out_byte = out_result.out_byte;
    assign o_out_last = out_result.out_last;
    assign o_status   = out_result.status;

endmodule

// ===== rtl/lhs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhs_front
// Accepts packet bytes, tracks the header walk and classifies each byte.
// ----------------------------------------------------------------------------
module lhs_front #(
    parameter int unsigned MAX_PACKET_BYTES = 65535
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_link_kind_we,
    input  logic [lhs_pkg::KIND_W-1:0]  i_link_kind,
    input  logic                        i_fire,
    input  logic [lhs_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                        i_first_byte,
    input  logic                        i_last_byte,
    input  logic [lhs_pkg::LEN_W-1:0]   i_packet_length,
    output logic                        o_push,
    output lhs_pkg::t_result            o_result
);
    import lhs_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES);

    logic [KIND_W-1:0]  r_kind;
    logic [POS_W-1:0]   r_pos,   n_pos;
    logic [LEN_W-1:0]   r_hend,  n_hend;
    logic               r_walk,  n_walk;
    logic [SHIFT_W-1:0] r_shift, n_shift;
    logic [BYTE_W-1:0]  r_eth,   n_eth;
    logic               r_mal,   n_mal;

    logic               start;
    logic [POS_W-1:0]   pos_e;
    logic [LEN_W-1:0]   pos16;
    logic [LEN_W-1:0]   hend_e;
    logic [LEN_W-1:0]   hend1;
    logic               walk1;
    logic [SHIFT_W-1:0] shift_e;
    logic [BYTE_W-1:0]  eth_e;
    logic               mal_e;
    logic [LEN_W-1:0]   rel;
    logic [LEN_W-1:0]   tlen;
    logic [LEN_W-1:0]   ttype;
    logic [LEN_W:0]     tspan;
    logic               payload;

    always_comb begin
        start   = i_first_byte || (r_pos == '0);
        pos_e   = start ? '0 : r_pos;
        pos16   = LEN_W'(pos_e);
        hend_e  = start ? hdr_len_of_kind(r_kind) : r_hend;
        shift_e = start ? '0 : r_shift;
        eth_e   = start ? '0 : r_eth;
        mal_e   = start ? 1'b0 : r_mal;
        walk1   = (r_kind == KIND_NFLOG) && (start ? 1'b1 : r_walk);

        n_eth = eth_e;
        if ((r_kind == KIND_ETHERNET && pos16 == ETH_TYPE_POS) ||
            (r_kind == KIND_SLL && pos16 == SLL_TYPE_POS)) begin
            n_eth = i_data_byte;
        end

        hend1 = hend_e;
        if (((r_kind == KIND_ETHERNET && pos16 == ETH_TYPE_POS + 16'd1) ||
             (r_kind == KIND_SLL && pos16 == SLL_TYPE_POS + 16'd1)) &&
            eth_e == VLAN_TPID_HIGH && i_data_byte == VLAN_TPID_LOW) begin
            hend1 = sat_add(hend_e, {1'b0, VLAN_TAG_LEN});
        end

        rel     = pos16 - hend1;
        tlen    = shift_e[LEN_W-1:0];
        ttype   = {i_data_byte, shift_e[SHIFT_W-1:LEN_W]};
        tspan   = ({1'b0, tlen} + 17'd3) & ~17'd3;
        n_hend  = hend1;
        n_walk  = walk1;
        n_shift = shift_e;
        n_mal   = mal_e;
        payload = 1'b0;

        if (!mal_e && pos16 >= hend1) begin
            if (walk1) begin
                if (rel == 16'd0) begin
                    if ({1'b0, hend1} + TLV_MIN_SPAN <= {1'b0, i_packet_length}) begin
                        n_shift = {16'd0, i_data_byte};
                    end else begin
                        n_walk  = 1'b0;
                        payload = 1'b1;
                    end
                end else if (rel == 16'd1) begin
                    n_shift = shift_e | {8'd0, i_data_byte, 8'd0};
                end else if (rel == 16'd2) begin
                    n_shift = shift_e | {i_data_byte, 16'd0};
                end else if (ttype == TLV_PAYLOAD_TYPE) begin
                    n_hend = sat_add(hend1, {1'b0, TLV_HDR_LEN});
                    n_walk = 1'b0;
                end else if (tlen >= TLV_HDR_LEN) begin
                    n_hend = sat_add(hend1, tspan);
                end else begin
                    n_mal  = 1'b1;
                    n_walk = 1'b0;
                end
            end else begin
                payload = 1'b1;
            end
        end

        if (i_last_byte) begin
            n_pos = '0;
        end else if (pos_e < POS_MAX) begin
            n_pos = pos_e + POS_W'(1);
        end else begin
            n_pos = pos_e;
        end

        o_push = i_fire && (payload || i_last_byte);
        if (payload) begin
            o_result.out_byte = i_data_byte;
            o_result.out_last = i_last_byte;
            o_result.status   = STATUS_PAYLOAD;
        end else begin
            o_result.out_byte = '0;
            o_result.out_last = 1'b1;
            o_result.status   = n_mal ? STATUS_MALFORMED : STATUS_SHORT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= KIND_ETHERNET;
            r_pos   <= '0;
            r_hend  <= '0;
            r_walk  <= 1'b0;
            r_shift <= '0;
            r_eth   <= '0;
            r_mal   <= 1'b0;
        end else begin
            if (i_link_kind_we) begin
                r_kind <= i_link_kind;
            end
            if (i_fire) begin
                r_pos   <= n_pos;
                r_hend  <= n_hend;
                r_walk  <= n_walk;
                r_shift <= n_shift;
                r_eth   <= n_eth;
                r_mal   <= n_mal;
            end
        end
    end

endmodule

// ===== rtl/lhs_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhs_queue
// Two-entry result queue that decouples classification from the output side.
// ----------------------------------------------------------------------------
module lhs_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lhs_pkg::t_result i_result,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_stall,
    output lhs_pkg::t_result o_result
);
    import lhs_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign pop      = (r_count != 2'd0) && !i_stall;
    assign o_valid  = (r_count != 2'd0);
    assign o_full   = (r_count == 2'd2);
    assign o_result = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== tb/link_header_stripper_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_header_stripper_core_tb
// Self-checking testbench for the link-layer header stripper.
//
// A behavioral predictor follows every accepted input item and queues the
// result it should cause. A monitor compares every accepted result with the
// oldest queued one. Directed tests cover VLAN tags, the NFLOG TLV walk, short
// and malformed packets, offset and position saturation, unsupported kinds and
// a kind change inside a packet. Random traffic then mixes well-formed
// packets of each kind with broken ones, under random idling on both sides.
// ----------------------------------------------------------------------------
module link_header_stripper_core_tb;

    import lhs_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int MAX_POSITION  = 64;
    localparam int LONG_PACKET   = 70;
    localparam int DRAIN_CYCLES  = 4;

    localparam logic [KIND_W-1:0] KIND_UNSUPPORTED = 4'd11;
    localparam logic [KIND_W-1:0] KIND_SPARE_LOW   = 4'd12;
    localparam logic [KIND_W-1:0] KIND_SPARE_HIGH  = 4'd15;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_link_kind_we;
    logic [KIND_W-1:0]    i_link_kind;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [BYTE_W-1:0]    i_data_byte;
    logic                 i_first_byte;
    logic                 i_last_byte;
    logic [LEN_W-1:0]     i_packet_length;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [BYTE_W-1:0]    o_out_byte;
    logic                 o_out_last;
    logic [STATUS_W-1:0]  o_status;

    link_header_stripper_core #(
        .MAX_PACKET_BYTES(MAX_POSITION)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_link_kind_we  (i_link_kind_we),
        .i_link_kind     (i_link_kind),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_first_byte    (i_first_byte),
        .i_last_byte     (i_last_byte),
        .i_packet_length (i_packet_length),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_out_last      (o_out_last),
        .o_status        (o_status)
    );

    t_result          expected_results[$];
    logic [7:0]       pkt_bytes[$];
    int               error_count;
    int               cycle_count;
    int               items_sent;
    bit               idling_enabled;
    int               hold_request;
    int               hold_left;
    int               stall_left;

    logic [KIND_W-1:0] model_kind;
    logic [15:0]       byte_pos;
    logic [15:0]       hdr_end;
    bit                tlv_walking;
    logic [23:0]       tlv_shift;
    logic [7:0]        type_high;
    bit                tlv_bad;

    always #5 i_clk = ~i_clk;

    function automatic logic [15:0] link_header_bytes(input logic [KIND_W-1:0] kind);
        int unsigned n;
        case (kind)
            KIND_ETHERNET: n = 14;
            KIND_802:      n = 22;
            KIND_NULL,
            KIND_PPP,
            KIND_NFLOG:    n = 4;
            KIND_SLIP,
            KIND_SLL:      n = 16;
            KIND_FDDI:     n = 21;
            KIND_ENC:      n = 12;
            KIND_IPNET:    n = 24;
            default:       n = 0;
        endcase
        return n[15:0];
    endfunction

    function automatic logic [15:0] add_clamped(input logic [15:0] a, input logic [16:0] b);
        logic [17:0] s;
        s = {2'b00, a} + {1'b0, b};
        if (s > 18'h0FFFF) begin
            return 16'hFFFF;
        end
        return s[15:0];
    endfunction

    function automatic bit predict_strip(input logic [7:0] b, input logic is_first,
                                         input logic is_last, input logic [15:0] plen,
                                         output t_result res);
        logic [15:0] pos;
        logic [15:0] rel;
        logic [15:0] tlen;
        logic [15:0] ttype;
        logic [16:0] span;
        bit          payload;
        payload = 1'b0;
        res     = '0;
        if (is_first || byte_pos == 16'd0) begin
            byte_pos    = 16'd0;
            hdr_end     = link_header_bytes(model_kind);
            tlv_walking = (model_kind == KIND_NFLOG);
            tlv_shift   = '0;
            type_high   = '0;
            tlv_bad     = 1'b0;
        end
        pos = byte_pos;
        if ((model_kind == KIND_ETHERNET && pos == ETH_TYPE_POS) ||
            (model_kind == KIND_SLL && pos == SLL_TYPE_POS)) begin
            type_high = b;
        end
        if ((model_kind == KIND_ETHERNET && pos == ETH_TYPE_POS + 16'd1) ||
            (model_kind == KIND_SLL && pos == SLL_TYPE_POS + 16'd1)) begin
            if (type_high == VLAN_TPID_HIGH && b == VLAN_TPID_LOW) begin
                hdr_end = add_clamped(hdr_end, {1'b0, VLAN_TAG_LEN});
            end
        end
        if (model_kind != KIND_NFLOG) begin
            tlv_walking = 1'b0;
        end
        if (!tlv_bad && pos >= hdr_end) begin
            if (tlv_walking) begin
                rel = pos - hdr_end;
                if (rel == 16'd0) begin
                    if ({1'b0, hdr_end} + 17'd8 <= {1'b0, plen}) begin
                        tlv_shift = {16'd0, b};
                    end else begin
                        tlv_walking = 1'b0;
                        payload     = 1'b1;
                    end
                end else if (rel < 16'd3) begin
                    tlv_shift = tlv_shift | ({16'd0, b} << (8 * rel));
                end else begin
                    tlen  = tlv_shift[15:0];
                    ttype = {b, tlv_shift[23:16]};
                    if (ttype == TLV_PAYLOAD_TYPE) begin
                        hdr_end     = add_clamped(hdr_end, {1'b0, TLV_HDR_LEN});
                        tlv_walking = 1'b0;
                    end else if (tlen >= 16'd4) begin
                        span    = ({1'b0, tlen} + 17'd3) & ~17'd3;
                        hdr_end = add_clamped(hdr_end, span);
                    end else begin
                        tlv_bad     = 1'b1;
                        tlv_walking = 1'b0;
                    end
                end
            end else begin
                payload = 1'b1;
            end
        end
        if (is_last) begin
            byte_pos = 16'd0;
        end else if (byte_pos < MAX_POSITION) begin
            byte_pos = byte_pos + 16'd1;
        end
        if (payload) begin
            res.out_byte = b;
            res.out_last = is_last;
            res.status   = STATUS_PAYLOAD;
            return 1'b1;
        end
        if (is_last) begin
            res.out_byte = '0;
            res.out_last = 1'b1;
            res.status   = tlv_bad ? STATUS_MALFORMED : STATUS_SHORT;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        cycle_count++;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result byte %0h last %0d status %0d",
                                              o_out_byte, o_out_last, o_status));
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_byte !== want.out_byte) begin
                        report_mismatch($sformatf("out_byte %0h, expected %0h",
                                                  o_out_byte, want.out_byte));
                    end
                    if (o_out_last !== want.out_last) begin
                        report_mismatch($sformatf("out_last %0d, expected %0d",
                                                  o_out_last, want.out_last));
                    end
                    if (o_status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_status, want.status));
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                if (predict_strip(i_data_byte, i_first_byte, i_last_byte,
                                  i_packet_length, got)) begin
                    expected_results.push_back(got);
                end
            end
            if (i_link_kind_we) begin
                model_kind = i_link_kind;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idling_enabled && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 12);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles", cycle_count);
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic is_first, input logic is_last,
                             input logic [15:0] plen);
        int gap;
        if (idling_enabled && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_data_byte     <= b;
        i_first_byte    <= is_first;
        i_last_byte     <= is_last;
        i_packet_length <= plen;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_packet(input logic [15:0] plen, input bit noisy);
        int n;
        n = pkt_bytes.size();
        for (int i = 0; i < n; i++) begin
            if (noisy) begin
                send_byte(pkt_bytes[i], $urandom_range(0, 9) == 0, $urandom_range(0, 7) == 0,
                          plen);
            end else begin
                send_byte(pkt_bytes[i], i == 0, i == n - 1, plen);
            end
        end
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_link_kind(input logic [KIND_W-1:0] kind);
        wait_results_drained();
        i_link_kind_we <= 1'b1;
        i_link_kind    <= kind;
        @(negedge i_clk);
        i_link_kind_we <= 1'b0;
    endtask

    task automatic push_random(input int n);
        repeat (n) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic push_tlv_head(input logic [15:0] len, input logic [15:0] kind_code);
        pkt_bytes.push_back(len[7:0]);
        pkt_bytes.push_back(len[15:8]);
        pkt_bytes.push_back(kind_code[7:0]);
        pkt_bytes.push_back(kind_code[15:8]);
    endtask

    task automatic build_nflog_packet();
        int          tlvs;
        int          bad_at;
        logic [15:0] len;
        logic [15:0] code;
        pkt_bytes.delete();
        push_random(4);
        tlvs   = $urandom_range(0, 3);
        bad_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, tlvs) : -1;
        for (int i = 0; i <= tlvs; i++) begin
            if (i == bad_at) begin
                push_tlv_head(16'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
                push_random($urandom_range(0, 6));
                break;
            end else if (i == tlvs) begin
                push_tlv_head(16'($urandom_range(4, 60)), TLV_PAYLOAD_TYPE);
                push_random($urandom_range(0, 16));
            end else begin
                len = 16'($urandom_range(4, 14));
                if ($urandom_range(0, 3) == 0) begin
                    code = 16'($urandom_range(256, 65535));
                end else begin
                    code = 16'($urandom_range(0, 8));
                end
                push_tlv_head(len, code);
                push_random(((len + 3) & ~16'd3) - 4);
            end
        end
    endtask

    task automatic build_typed_packet(input logic [KIND_W-1:0] kind);
        int          type_pos;
        int          pick;
        int          cut;
        logic [7:0]  hi;
        logic [7:0]  lo;
        pkt_bytes.delete();
        type_pos = (kind == KIND_SLL) ? SLL_TYPE_POS : ETH_TYPE_POS;
        push_random(type_pos);
        pick = $urandom_range(0, 3);
        hi   = (pick <= 1) ? VLAN_TPID_HIGH : 8'($urandom_range(0, 255));
        lo   = (pick == 0 || pick == 2) ? VLAN_TPID_LOW : 8'($urandom_range(0, 255));
        pkt_bytes.push_back(hi);
        pkt_bytes.push_back(lo);
        if (hi == VLAN_TPID_HIGH && lo == VLAN_TPID_LOW) begin
            push_random(4);
        end
        push_random($urandom_range(0, 20));
        if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, pkt_bytes.size());
            while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
        end
    endtask

    task automatic build_packet(input logic [KIND_W-1:0] kind);
        if (kind == KIND_NFLOG) begin
            build_nflog_packet();
        end else if (kind == KIND_ETHERNET || kind == KIND_SLL) begin
            build_typed_packet(kind);
        end else begin
            pkt_bytes.delete();
            push_random($urandom_range(1, link_header_bytes(kind) + 12));
        end
    endtask

    task automatic test_short_and_single();
        write_link_kind(KIND_RAW);
        pkt_bytes.delete();
        pkt_bytes.push_back(8'hFF);
        send_packet(16'd1, 1'b0);
        write_link_kind(KIND_ETHERNET);
        pkt_bytes.delete();
        push_random(10);
        send_packet(16'd10, 1'b0);
    endtask

    task automatic test_vlan_tags();
        write_link_kind(KIND_ETHERNET);
        pkt_bytes.delete();
        repeat (6) pkt_bytes.push_back(8'h00);
        repeat (6) pkt_bytes.push_back(8'hFF);
        pkt_bytes.push_back(VLAN_TPID_HIGH);
        pkt_bytes.push_back(VLAN_TPID_LOW);
        push_random(4);
        pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(8'hFF);
        send_packet(16'hFFFF, 1'b0);
        write_link_kind(KIND_SLL);
        pkt_bytes.delete();
        push_random(14);
        pkt_bytes.push_back(VLAN_TPID_HIGH);
        pkt_bytes.push_back(VLAN_TPID_LOW);
        push_random(5);
        send_packet(16'd0, 1'b0);
    endtask

    task automatic test_nflog_walk();
        write_link_kind(KIND_NFLOG);
        pkt_bytes.delete();
        push_random(4);
        push_tlv_head(16'd8, 16'd1);
        push_random(4);
        push_tlv_head(16'd9, TLV_PAYLOAD_TYPE);
        push_random(5);
        send_packet(16'd21, 1'b0);
        pkt_bytes.delete();
        push_random(4);
        push_tlv_head(16'd2, 16'd1);
        push_random(2);
        send_packet(16'd10, 1'b0);
    endtask

    task automatic test_header_saturation();
        write_link_kind(KIND_NFLOG);
        pkt_bytes.delete();
        push_random(4);
        push_tlv_head(16'hFFFF, 16'd1);
        push_random(8);
        send_packet(16'hFFFF, 1'b0);
    endtask

    task automatic test_kind_switch_mid_packet();
        write_link_kind(KIND_ETHERNET);
        pkt_bytes.delete();
        push_random(10);
        for (int i = 0; i < 10; i++) begin
            send_byte(pkt_bytes[i], i == 0, 1'b0, 16'd20);
        end
        write_link_kind(KIND_SLL);
        pkt_bytes.delete();
        push_random(4);
        pkt_bytes.push_back(VLAN_TPID_HIGH);
        pkt_bytes.push_back(VLAN_TPID_LOW);
        push_random(4);
        for (int i = 0; i < 10; i++) begin
            send_byte(pkt_bytes[i], 1'b0, i == 9, 16'd20);
        end
    endtask

    task automatic test_unsupported_kinds();
        write_link_kind(KIND_UNSUPPORTED);
        pkt_bytes.delete();
        push_random(2);
        send_packet(16'd2, 1'b0);
        write_link_kind(KIND_SPARE_LOW);
        send_packet(16'd2, 1'b0);
        write_link_kind(KIND_SPARE_HIGH);
        send_packet(16'd2, 1'b0);
    endtask

    task automatic test_backpressure();
        write_link_kind(KIND_RAW);
        idling_enabled = 1'b0;
        hold_request   = 60;
        pkt_bytes.delete();
        push_random(24);
        send_packet(16'd24, 1'b0);
        wait_results_drained();
        idling_enabled = 1'b1;
        push_random(8);
        send_packet(16'd32, 1'b0);
    endtask

    task automatic test_position_saturation();
        write_link_kind(KIND_ETHERNET);
        idling_enabled = 1'b0;
        for (int i = 0; i < LONG_PACKET; i++) begin
            send_byte(8'($urandom_range(0, 255)), i == 0, i == LONG_PACKET - 1, 16'hFFFF);
        end
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        int          start;
        int          pick;
        logic [3:0]  kind;
        logic [15:0] plen;
        bit          noisy;
        start          = items_sent;
        idling_enabled = 1'b1;
        while (items_sent - start < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick <= 2) begin
                kind = KIND_NFLOG;
            end else if (pick <= 4) begin
                kind = KIND_ETHERNET;
            end else if (pick <= 6) begin
                kind = KIND_SLL;
            end else begin
                kind = 4'($urandom_range(0, 15));
            end
            write_link_kind(kind);
            repeat ($urandom_range(3, 8)) begin
                if (items_sent - start > RANDOM_ITEMS - 200) begin
                    idling_enabled = 1'b0;
                end
                build_packet(kind);
                pick  = $urandom_range(0, 9);
                plen  = 16'(pkt_bytes.size());
                if (pick == 0) begin
                    plen = 16'($urandom_range(0, 65535));
                end else if (pick == 1) begin
                    plen = 16'($urandom_range(0, pkt_bytes.size()));
                end
                noisy = ($urandom_range(0, 11) == 0);
                send_packet(plen, noisy);
            end
        end
        idling_enabled = 1'b0;
    endtask

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_link_kind_we  = 1'b0;
        i_link_kind     = '0;
        i_in_valid      = 1'b0;
        i_data_byte     = '0;
        i_first_byte    = 1'b0;
        i_last_byte     = 1'b0;
        i_packet_length = '0;
        i_out_stall     = 1'b0;
        error_count     = 0;
        cycle_count     = 0;
        items_sent      = 0;
        idling_enabled  = 1'b1;
        hold_request    = 0;
        hold_left       = 0;
        stall_left      = 0;
        model_kind      = KIND_ETHERNET;
        byte_pos        = '0;
        hdr_end         = '0;
        tlv_walking     = 1'b0;
        tlv_shift       = '0;
        type_high       = '0;
        tlv_bad         = 1'b0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_short_and_single();
        test_vlan_tags();
        test_nflog_walk();
        test_header_saturation();
        test_kind_switch_mid_packet();
        test_unsupported_kinds();
        test_backpressure();
        test_position_saturation();
        test_random_traffic();

        wait_results_drained();
        repeat (16) @(negedge i_clk);
        if (expected_results.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_results.size()));
        end
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
